### src/agsl_pkg.sv
// ----------------------------------------------------------------------------
// agsl_pkg
// Shared types, constants and the exponential table builder for the audio
// gain smoother and soft limiter.
// ----------------------------------------------------------------------------
package agsl_pkg;

    // Default sizes.
    localparam int EXP_TABLE_SIZE_DEF = 256;
    localparam int MAX_CHANNELS_DEF   = 8;
    localparam int QUEUE_DEPTH        = 2;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SAMPLE_FORMAT = 3'd0,
        CFG_VALID_BITS    = 3'd1,
        CFG_PADDING_BITS  = 3'd2,
        CFG_CHANNEL_COUNT = 3'd3,
        CFG_MUTED         = 3'd4,
        CFG_TARGET_GAIN   = 3'd5,
        CFG_SMOOTHING     = 3'd6,
        CFG_UNUSED        = 3'd7
    } cfg_index_t;

    // Sample format codes.
    localparam logic [2:0] FMT_FLOAT32 = 3'd0;
    localparam logic [2:0] FMT_PCM16   = 3'd1;
    localparam logic [2:0] FMT_PCM24   = 3'd2;
    localparam logic [2:0] FMT_PCM32   = 3'd3;

    // Limiter constants in Q7.24.
    localparam logic [23:0] KNEE_Q24   = 24'd13421773;
    localparam logic [23:0] CEIL_Q24   = 24'd14952710;
    localparam logic [20:0] SPAN_Q24   = 21'd1530937;
    // Excess over the knee at which the table index runs past its end.
    localparam logic [31:0] SPAN_LIMIT = 32'd24494992;
    // Reciprocal of the span scaled by 2^41, rounded down. An estimate of
    // excess * 2^16 / span from it is exact or one short.
    localparam logic [20:0] SPAN_RECIP = 21'((64'd1 << 41) / 64'(SPAN_Q24));

    localparam logic [17:0] UNITY_GAIN = 18'd65536;

    // Configuration register set.
    typedef struct packed {
        logic [2:0]  sample_format;
        logic [5:0]  valid_bits;
        logic [4:0]  padding_bits;
        logic [3:0]  channel_count;
        logic        muted;
        logic [16:0] target_gain;
        logic [15:0] smoothing;
    } cfg_t;

    // How the back end treats an item.
    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_MUTE,
        KIND_PROC
    } kind_t;

    // One queued request from the front end to the back end.
    typedef struct packed {
        logic [31:0] sample_bits;
        logic        start_of_block;
        kind_t       kind;
        logic        frame_start;
    } item_t;

    // Entry i of the table is exp(-16 i / size) in Q1.16, built from a Taylor
    // series of the step and repeated rounded Q30 multiplication.
    function automatic logic [16:0] exp_entry(input int unsigned idx,
                                              input logic [63:0] step);
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        ratio;
        logic [63:0]        q;
        logic [63:0]        rounded;
        term = 64'd1 << 30;
        sum  = 64'sd1 << 30;
        for (int k = 1; k <= 14; k++) begin
            term = ((term * step) >> 30) / 64'(k);
            if (k % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        ratio = $unsigned(sum);
        q     = 64'd1 << 30;
        for (int unsigned i = 0; i < idx; i++) begin
            q = (q * ratio + (64'd1 << 29)) >> 30;
        end
        rounded = (q + 64'd8192) >> 14;
        return rounded[16:0];
    endfunction

endpackage

### src/audio_gain_smoother_soft_limiter.sv
// ----------------------------------------------------------------------------
// audio_gain_smoother_soft_limiter
// Smoothed gain, soft-knee limiter and peak metering on an interleaved stream.
// ----------------------------------------------------------------------------
// The back end carries out one sample at a time and waits while the output
// register is held by back-pressure. Pass-through and muted samples take
// its shortest path; a frame-start sample above the knee, with its gain
// step and reciprocal division, takes the longest. The queue lets the front
// end accept further samples while the back end is busy.
// Reset: configuration to defaults, gain to unity, meters and position cleared.
module audio_gain_smoother_soft_limiter #(
    parameter int EXP_TABLE_SIZE = agsl_pkg::EXP_TABLE_SIZE_DEF,
    parameter int MAX_CHANNELS   = agsl_pkg::MAX_CHANNELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_bits[31:0]
    input  logic        s_tuser,   // start_of_block
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // sample_out[31:0], peak_level[47:32]
    output logic        m_tuser    // limit_flag
);
    import agsl_pkg::*;

    cfg_t  cfg_reg;
    logic  q_full;
    logic  q_push;
    item_t q_item;
    logic  q_pop;
    logic  q_not_empty;
    item_t q_head;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_format <= FMT_PCM16;
            cfg_reg.valid_bits    <= 6'd16;
            cfg_reg.padding_bits  <= 5'd0;
            cfg_reg.channel_count <= 4'd2;
            cfg_reg.muted         <= 1'b0;
            cfg_reg.target_gain   <= 17'd65536;
            cfg_reg.smoothing     <= 16'd137;
        end else if (cfg_wen) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SAMPLE_FORMAT: cfg_reg.sample_format <= cfg_wdata[2:0];
                CFG_VALID_BITS:    cfg_reg.valid_bits    <= cfg_wdata[5:0];
                CFG_PADDING_BITS:  cfg_reg.padding_bits  <= cfg_wdata[4:0];
                CFG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_wdata[3:0];
                CFG_MUTED:         cfg_reg.muted         <= cfg_wdata[0];
                CFG_TARGET_GAIN:   cfg_reg.target_gain   <= cfg_wdata;
                CFG_SMOOTHING:     cfg_reg.smoothing     <= cfg_wdata[15:0];
                CFG_UNUSED: begin
                end
                default: begin
                end
            endcase
        end
    end

    agsl_front #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    agsl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    agsl_back #(
        .EXP_TABLE_SIZE(EXP_TABLE_SIZE)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

### src/agsl_front.sv
// ----------------------------------------------------------------------------
// agsl_front
// Accepts input samples, tracks the channel position within the frame and
// classifies each sample for the back end.
// ----------------------------------------------------------------------------
module agsl_front #(
    parameter int MAX_CHANNELS = agsl_pkg::MAX_CHANNELS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  agsl_pkg::cfg_t cfg,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [31:0]    s_tdata,   // sample_bits[31:0]
    input  logic           s_tuser,   // start_of_block
    input  logic           q_full,
    output logic           q_push,
    output agsl_pkg::item_t q_item
);
    import agsl_pkg::*;

    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] pos_cur;
    logic [CW-1:0] count;

    // Effective channel count, clamped into one to the maximum.
    always_comb begin
        if (cfg.channel_count == 4'd0) begin
            count = CW'(1);
        end else if (int'(cfg.channel_count) > MAX_CHANNELS) begin
            count = CW'(MAX_CHANNELS);
        end else begin
            count = CW'(cfg.channel_count);
        end
    end

    // Position of this sample and of the next one.
    always_comb begin
        if (s_tuser || ((CW+1)'(pos_reg) >= (CW+1)'(count))) begin
            pos_cur = '0;
        end else begin
            pos_cur = pos_reg;
        end
        if ((CW+1)'(pos_cur) + (CW+1)'(1) >= (CW+1)'(count)) begin
            pos_next = '0;
        end else begin
            pos_next = pos_cur + PW'(1);
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // Classify the request.
    always_comb begin
        q_item.sample_bits    = s_tdata;
        q_item.start_of_block = s_tuser;
        q_item.frame_start    = (pos_cur == '0);
        if (cfg.sample_format > FMT_PCM32) begin
            q_item.kind = KIND_PASS;
        end else if (cfg.muted) begin
            q_item.kind = KIND_MUTE;
        end else begin
            q_item.kind = KIND_PROC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (q_push) begin
            pos_reg <= pos_next;
        end
    end

endmodule

### src/agsl_queue.sv
// ----------------------------------------------------------------------------
// agsl_queue
// Short queue of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module agsl_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  agsl_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output agsl_pkg::item_t head
);
    import agsl_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    item_t         mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign full      = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (AW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

endmodule

### src/agsl_back.sv
// ----------------------------------------------------------------------------
// agsl_back
// Sequencer that carries out one request: gain smoothing, decode, scaling,
// soft-knee limiting, metering and re-encoding, with an output register.
// ----------------------------------------------------------------------------
module agsl_back #(
    parameter int EXP_TABLE_SIZE = agsl_pkg::EXP_TABLE_SIZE_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  agsl_pkg::cfg_t  cfg,
    input  logic            q_not_empty,
    input  agsl_pkg::item_t q_head,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [47:0]     m_tdata,   // sample_out[31:0], peak_level[47:32]
    output logic            m_tuser    // limit_flag
);
    import agsl_pkg::*;

    localparam int          IDX_W    = $clog2(EXP_TABLE_SIZE);
    localparam int          P_W      = 21 + IDX_W;
    localparam logic [63:0] EXP_STEP = (64'd16 << 30) / EXP_TABLE_SIZE;

    typedef enum logic [3:0] {
        ST_IDLE, ST_GAIN_MUL, ST_GAIN_ADD, ST_DECODE, ST_SCALE, ST_SAT,
        ST_DIV, ST_DIV_CHK, ST_DIV_FIX, ST_INDEX, ST_INTERP, ST_COMP,
        ST_FINISH, ST_ENCODE, ST_DONE
    } state_t;

    // Exponential table as constant logic.
    logic [16:0] exp_rom [EXP_TABLE_SIZE];
    for (genvar gi = 0; gi < EXP_TABLE_SIZE; gi++) begin : g_rom
        localparam logic [16:0] ROM_VAL = exp_entry(gi, EXP_STEP);
        assign exp_rom[gi] = ROM_VAL;
    end

    state_t             state_reg;
    logic [31:0]        bits_reg;
    kind_t              kind_reg;
    logic [17:0]        gain_reg;
    logic [15:0]        peak_reg;
    logic               limit_reg;
    logic signed [35:0] gprod_reg;
    logic signed [31:0] x_reg;
    logic signed [50:0] sprod_reg;
    logic [24:0]        exc_reg;
    logic [44:0]        rprod_reg;
    logic [40:0]        uprod_reg;
    logic [19:0]        u_reg;
    logic [16:0]        e0_reg;
    logic [16:0]        e1_reg;
    logic [15:0]        frac_reg;
    logic [16:0]        e_reg;
    logic [23:0]        lim_mag_reg;
    logic               lim_neg_reg;
    logic               hit_reg;
    logic [55:0]        enc_prod_reg;
    logic [31:0]        res_sample_reg;
    logic               m_valid_reg;
    logic [47:0]        m_data_reg;
    logic               m_user_reg;
    logic               out_load;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign q_pop    = (state_reg == ST_IDLE) && q_not_empty;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
        if (v > 56'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -56'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    // Effective valid bits, clamped into two to thirty-two.
    logic [5:0] vb_eff;
    always_comb begin
        if (cfg.valid_bits < 6'd2) begin
            vb_eff = 6'd2;
        end else if (cfg.valid_bits > 6'd32) begin
            vb_eff = 6'd32;
        end else begin
            vb_eff = cfg.valid_bits;
        end
    end

    // Decode the container to Q7.24.
    logic signed [31:0] dec_x;
    logic               dec_nonfinite;
    always_comb begin
        logic signed [31:0] raw;
        logic signed [31:0] shifted;
        logic signed [55:0] wide;
        logic [7:0]         fexp;
        logic [23:0]        mant;
        logic signed [9:0]  sexp;
        logic [9:0]         nsh;
        logic [32:0]        fmag;
        logic signed [55:0] fval;
        fexp          = bits_reg[30:23];
        dec_nonfinite = 1'b0;
        dec_x         = '0;
        raw           = '0;
        shifted       = '0;
        wide          = '0;
        mant          = '0;
        sexp          = '0;
        nsh           = '0;
        fmag          = '0;
        fval          = '0;
        if (cfg.sample_format == FMT_FLOAT32) begin
            if (fexp == 8'hFF) begin
                dec_nonfinite = 1'b1;
            end else begin
                if (fexp == 8'd0) begin
                    mant = {1'b0, bits_reg[22:0]};
                    sexp = -10'sd125;
                end else begin
                    mant = {1'b1, bits_reg[22:0]};
                    sexp = $signed({2'b00, fexp}) - 10'sd126;
                end
                nsh = 10'(-sexp);
                if (mant == '0) begin
                    fmag = '0;
                end else if (sexp >= 10'sd8) begin
                    fmag = 33'h1_0000_0000;
                end else if (sexp >= 10'sd0) begin
                    fmag = 33'(mant) << sexp[2:0];
                end else if (nsh < 10'd32) begin
                    fmag = 33'(mant) >> nsh[4:0];
                end else begin
                    fmag = '0;
                end
                fval  = bits_reg[31] ? -$signed(56'(fmag)) : $signed(56'(fmag));
                dec_x = sat32(fval);
            end
        end else begin
            if (cfg.sample_format == FMT_PCM16) begin
                raw = {{16{bits_reg[15]}}, bits_reg[15:0]};
            end else if (cfg.sample_format == FMT_PCM24) begin
                raw = {{8{bits_reg[23]}}, bits_reg[23:0]};
            end else begin
                raw = bits_reg;
            end
            shifted = raw >>> cfg.padding_bits;
            if (vb_eff <= 6'd25) begin
                wide  = {{24{shifted[31]}}, shifted} <<< (6'd25 - vb_eff);
                dec_x = sat32(wide);
            end else begin
                dec_x = shifted >>> (vb_eff - 6'd25);
            end
        end
    end

    // Gain step arithmetic.
    logic signed [18:0] gdiff;
    logic signed [19:0] gstep;
    logic signed [20:0] gsum;
    logic signed [35:0] gprod_rnd;
    always_comb begin
        gdiff     = $signed({2'b00, cfg.target_gain}) - $signed({1'b0, gain_reg});
        gprod_rnd = (gprod_reg + 36'sd32768) >>> 16;
        gstep     = gprod_rnd[19:0];
        gsum      = $signed({3'b000, gain_reg}) + {gstep[19], gstep};
    end

    // Scaled value and its magnitude.
    logic signed [50:0] srnd;
    logic signed [31:0] xs;
    logic [31:0]        xs_mag;
    logic [31:0]        excess;
    always_comb begin
        srnd   = (sprod_reg + 51'sd32768) >>> 16;
        xs     = sat32({{5{srnd[50]}}, srnd});
        xs_mag = xs[31] ? 32'(-xs) : 32'(xs);
        excess = xs_mag - 32'(KNEE_Q24);
    end

    // Remainder left by the reciprocal estimate of the quotient.
    logic [40:0] div_left;
    assign div_left = {exc_reg, 16'd0} - uprod_reg;

    // Table position.
    logic [P_W-1:0]   tpos;
    logic [IDX_W-1:0] tidx;
    logic [IDX_W-1:0] tidx_p1;
    assign tpos    = P_W'(u_reg) * P_W'(EXP_TABLE_SIZE);
    assign tidx    = tpos[20 +: IDX_W];
    assign tidx_p1 = tidx + IDX_W'(1);

    // Interpolation and compression curve.
    logic [16:0] ediff;
    logic [32:0] eprod;
    logic [16:0] e_int;
    logic [37:0] cprod;
    logic [24:0] comp;
    always_comb begin
        ediff = e0_reg - e1_reg;
        eprod = 33'(ediff) * 33'(frac_reg);
        if (e0_reg >= e1_reg) begin
            e_int = e0_reg - eprod[32:16];
        end else begin
            e_int = e0_reg;
        end
        if (e_int > 17'd65536) begin
            e_int = 17'd65536;
        end
        cprod = 38'(SPAN_Q24) * 38'(17'd65536 - e_reg);
        comp  = 25'(KNEE_Q24) + 25'((cprod + 38'd32768) >> 16);
        if (comp > 25'(CEIL_Q24)) begin
            comp = 25'(CEIL_Q24);
        end
    end

    // Encode the limited value.
    logic [31:0] max_code;
    logic [31:0] enc_out;
    always_comb begin
        logic [55:0] qr;
        logic [31:0] qv;
        logic [4:0]  lead;
        logic [23:0] norm;
        max_code = (32'd1 << (vb_eff - 6'd1)) - 32'd1;
        qr       = (enc_prod_reg + 56'd8388608) >> 24;
        qv       = lim_neg_reg ? 32'd0 - qr[31:0] : qr[31:0];
        qv       = qv << cfg.padding_bits;
        lead     = '0;
        for (int b = 0; b < 24; b++) begin
            if (lim_mag_reg[b]) begin
                lead = 5'(b);
            end
        end
        norm = lim_mag_reg << (5'd23 - lead);
        if (cfg.sample_format == FMT_FLOAT32) begin
            if (lim_mag_reg == '0) begin
                enc_out = '0;
            end else begin
                enc_out = {lim_neg_reg, 8'(lead) + 8'd103, norm[22:0]};
            end
        end else if (cfg.sample_format == FMT_PCM16) begin
            enc_out = {16'd0, qv[15:0]};
        end else if (cfg.sample_format == FMT_PCM24) begin
            enc_out = {8'd0, qv[23:0]};
        end else begin
            enc_out = qv;
        end
    end

    // Sequencer, state and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gain_reg    <= UNITY_GAIN;
            peak_reg    <= '0;
            limit_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_not_empty) begin
                        bits_reg  <= q_head.sample_bits;
                        kind_reg  <= q_head.kind;
                        hit_reg   <= 1'b0;
                        if (q_head.start_of_block) begin
                            peak_reg  <= '0;
                            limit_reg <= 1'b0;
                        end
                        if (q_head.kind == KIND_PASS) begin
                            res_sample_reg <= q_head.sample_bits;
                            state_reg      <= ST_DONE;
                        end else if (q_head.kind == KIND_MUTE) begin
                            res_sample_reg <= '0;
                            state_reg      <= ST_DONE;
                        end else if (q_head.frame_start) begin
                            state_reg <= ST_GAIN_MUL;
                        end else begin
                            state_reg <= ST_DECODE;
                        end
                    end
                end
                ST_GAIN_MUL: begin
                    gprod_reg <= gdiff * $signed({1'b0, cfg.smoothing});
                    state_reg <= ST_GAIN_ADD;
                end
                ST_GAIN_ADD: begin
                    if (gsum < 0) begin
                        gain_reg <= '0;
                    end else if (gsum > 21'sd262143) begin
                        gain_reg <= 18'h3FFFF;
                    end else begin
                        gain_reg <= gsum[17:0];
                    end
                    state_reg <= ST_DECODE;
                end
                ST_DECODE: begin
                    x_reg <= dec_x;
                    if (dec_nonfinite) begin
                        lim_mag_reg <= '0;
                        lim_neg_reg <= 1'b0;
                        hit_reg     <= 1'b1;
                        state_reg   <= ST_FINISH;
                    end else begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    sprod_reg <= x_reg * $signed({1'b0, gain_reg});
                    state_reg <= ST_SAT;
                end
                ST_SAT: begin
                    lim_neg_reg <= xs[31];
                    if (xs_mag <= 32'(KNEE_Q24)) begin
                        lim_mag_reg <= xs_mag[23:0];
                        state_reg   <= ST_FINISH;
                    end else begin
                        hit_reg <= 1'b1;
                        if (excess >= SPAN_LIMIT) begin
                            e_reg     <= '0;
                            state_reg <= ST_COMP;
                        end else begin
                            exc_reg   <= excess[24:0];
                            state_reg <= ST_DIV;
                        end
                    end
                end
                // Quotient estimate by multiplying with the reciprocal.
                ST_DIV: begin
                    rprod_reg <= 45'(45'(exc_reg) * 45'(SPAN_RECIP));
                    state_reg <= ST_DIV_CHK;
                end
                ST_DIV_CHK: begin
                    u_reg     <= rprod_reg[44:25];
                    uprod_reg <= 41'(rprod_reg[44:25]) * 41'(SPAN_Q24);
                    state_reg <= ST_DIV_FIX;
                end
                // The estimate is at most one short; correct it.
                ST_DIV_FIX: begin
                    if (div_left >= 41'(SPAN_Q24)) begin
                        u_reg <= u_reg + 20'd1;
                    end
                    state_reg <= ST_INDEX;
                end
                ST_INDEX: begin
                    e0_reg   <= exp_rom[tidx];
                    e1_reg   <= (tidx == IDX_W'(EXP_TABLE_SIZE - 1)) ? '0 : exp_rom[tidx_p1];
                    frac_reg <= tpos[19:4];
                    state_reg <= ST_INTERP;
                end
                ST_INTERP: begin
                    e_reg     <= e_int;
                    state_reg <= ST_COMP;
                end
                ST_COMP: begin
                    lim_mag_reg <= comp[23:0];
                    state_reg   <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (hit_reg) begin
                        limit_reg <= 1'b1;
                    end
                    if (lim_mag_reg[23:8] > peak_reg) begin
                        peak_reg <= lim_mag_reg[23:8];
                    end
                    enc_prod_reg <= 56'(lim_mag_reg) * 56'(max_code);
                    state_reg    <= ST_ENCODE;
                end
                ST_ENCODE: begin
                    res_sample_reg <= enc_out;
                    state_reg      <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_load) begin
                        if (kind_reg == KIND_MUTE) begin
                            m_data_reg <= '0;
                            m_user_reg <= 1'b0;
                        end else begin
                            m_data_reg <= {peak_reg, res_sample_reg};
                            m_user_reg <= limit_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### verif/audio_gain_smoother_soft_limiter_test.sv
// ----------------------------------------------------------------------------
// audio_gain_smoother_soft_limiter_test
// Self-checking bench for the gain smoother and soft limiter. A cycle-free
// model of the decode, gain ramp, limiter, meters and encode predicts every
// result. Directed cases cover the special cases. Randomized phases then run
// under changing settings and changing amounts of source and sink idling.
// ----------------------------------------------------------------------------
module audio_gain_smoother_soft_limiter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import agsl_pkg::*;

    localparam int ROM_SIZE   = 256;
    localparam int CHAN_LIMIT = 8;
    localparam longint KNEE   = 13421773;
    localparam longint CEIL   = 14952710;
    localparam longint SPAN   = CEIL - KNEE;
    localparam longint S32MAX = 64'sd2147483647;
    localparam longint S32MIN = -64'sd2147483648;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [31:0] sample_out;
        logic [15:0] peak_level;
        logic        limit_flag;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [16:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    // Bench copy of the registers and the block state.
    int unsigned r_format, r_valid, r_pad, r_chans, r_mute, r_target, r_smooth;
    int unsigned gain_now, chan_pos, peak_now, limit_now;
    longint unsigned decay_rom [ROM_SIZE];

    result_t expected_results [$];
    int      send_idle_pct = 0;
    int      sink_stall_pct = 0;
    bit      failed = 1'b0;
    int      quiet_cycles = 0;

    audio_gain_smoother_soft_limiter dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #10 aclk = ~aclk;

    // Table of exp(-16 i / size): Taylor series for one step, then repeated
    // rounded Q30 products.
    function automatic void build_decay_rom();
        longint unsigned step, term, ratio, q;
        longint sum;
        step = (longint'(16) << 30) / ROM_SIZE;
        term = 64'd1 << 30;
        sum = longint'(1) << 30;
        for (int k = 1; k <= 14; k++) begin
            term = ((term * step) >> 30) / k;
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        ratio = longint'(sum);
        q = 64'd1 << 30;
        for (int i = 0; i < ROM_SIZE; i++) begin
            decay_rom[i] = (q + 8192) >> 14;
            q = (q * ratio + (64'd1 << 29)) >> 30;
        end
    endfunction

    function automatic longint clip32(longint v);
        if (v > S32MAX) return S32MAX;
        if (v < S32MIN) return S32MIN;
        return v;
    endfunction

    function automatic int unsigned width_used();
        if (r_valid < 2) return 2;
        if (r_valid > 32) return 32;
        return r_valid;
    endfunction

    // Container to Q7.24; returns 0 for a non-finite float.
    function automatic bit to_fixed(logic [31:0] b, output longint x);
        longint v;
        longint unsigned m, mag;
        int s;
        int unsigned vb;
        vb = width_used();
        x = 0;
        if (r_format == FMT_FLOAT32) begin
            if (b[30:23] == 8'hFF) return 1'b0;
            if (b[30:23] == 0) begin
                m = b[22:0];
                s = -125;
            end else begin
                m = {1'b1, b[22:0]};
                s = int'(b[30:23]) - 126;
            end
            if (m == 0) mag = 0;
            else if (s >= 8) mag = 64'd1 << 32;
            else if (s >= 0) mag = m << s;
            else if (-s < 32) mag = m >> (-s);
            else mag = 0;
            x = clip32(b[31] ? -longint'(mag) : longint'(mag));
            return 1'b1;
        end
        if (r_format == FMT_PCM16) v = longint'($signed(b[15:0]));
        else if (r_format == FMT_PCM24) v = longint'($signed(b[23:0]));
        else v = longint'($signed(b));
        v = v >>> r_pad;
        if (vb <= 25) v = clip32(v * (longint'(1) << (25 - vb)));
        else v = v >>> (vb - 25);
        x = v;
        return 1'b1;
    endfunction

    function automatic longint knee_compress(longint x, inout bit hit);
        longint unsigned mag, u, p, idx, frac, e0, e1, e, comp;
        mag = x < 0 ? -x : x;
        if (mag <= KNEE) return x;
        hit = 1'b1;
        u = ((mag - KNEE) << 16) / SPAN;
        p = u * ROM_SIZE;
        idx = p >> 20;
        frac = (p >> 4) & 64'hFFFF;
        if (idx >= ROM_SIZE) begin
            e = 0;
        end else begin
            e0 = decay_rom[idx];
            e1 = (idx + 1 < ROM_SIZE) ? decay_rom[idx + 1] : 0;
            e = e0 >= e1 ? e0 - (((e0 - e1) * frac) >> 16) : e0;
        end
        if (e > 65536) e = 65536;
        comp = KNEE + ((SPAN * (65536 - e) + 32768) >> 16);
        if (comp > CEIL) comp = CEIL;
        return x < 0 ? -longint'(comp) : longint'(comp);
    endfunction

    function automatic logic [31:0] to_container(longint v);
        longint unsigned m, maxv, q;
        int p;
        if (v > 16777216) v = 16777216;
        if (v < -16777216) v = -16777216;
        m = v < 0 ? -v : v;
        if (r_format == FMT_FLOAT32) begin
            if (m == 0) return 32'd0;
            p = 0;
            while ((m >> (p + 1)) != 0) p++;
            m = (p <= 23) ? (m << (23 - p)) : (m >> (p - 23));
            return {v < 0, 8'(p + 103), m[22:0]};
        end
        maxv = (64'd1 << (width_used() - 1)) - 1;
        q = (m * maxv + (64'd1 << 23)) >> 24;
        if (v < 0) q = 64'd0 - q;
        q = q << r_pad;
        if (r_format == FMT_PCM16) return {16'd0, q[15:0]};
        if (r_format == FMT_PCM24) return {8'd0, q[23:0]};
        return q[31:0];
    endfunction

    // Advances the bench state by one sample and returns the result it gives.
    function automatic result_t process_sample(logic [31:0] bits, logic sob);
        result_t r;
        int unsigned cnt, here;
        longint d, g, x, lim;
        longint unsigned pk;
        bit hit;
        if (sob) begin
            peak_now = 0;
            limit_now = 0;
            chan_pos = 0;
        end
        cnt = r_chans == 0 ? 1 : (r_chans > CHAN_LIMIT ? CHAN_LIMIT : r_chans);
        if (chan_pos >= cnt) chan_pos = 0;
        here = chan_pos;
        chan_pos = (here + 1 >= cnt) ? 0 : here + 1;
        if (r_format > FMT_PCM32) begin
            r.sample_out = bits;
            r.peak_level = 16'(peak_now);
            r.limit_flag = limit_now[0];
            return r;
        end
        if (r_mute) begin
            r.sample_out = '0;
            r.peak_level = '0;
            r.limit_flag = 1'b0;
            return r;
        end
        // Gain ramps once per frame, at channel zero.
        if (here == 0) begin
            d = (longint'(r_target) - longint'(gain_now)) * longint'(r_smooth);
            g = longint'(gain_now) + ((d + 32768) >>> 16);
            if (g < 0) g = 0;
            if (g > 262143) g = 262143;
            gain_now = 32'(g);
        end
        hit = 1'b0;
        if (!to_fixed(bits, x)) begin
            lim = 0;
            hit = 1'b1;
        end else begin
            x = clip32((x * longint'(gain_now) + 32768) >>> 16);
            lim = knee_compress(x, hit);
        end
        if (hit) limit_now = 1;
        pk = (lim < 0 ? -lim : lim) >> 8;
        if (pk > 16'hFFFF) pk = 16'hFFFF;
        if (pk > peak_now) peak_now = 32'(pk);
        r.sample_out = to_container(lim);
        r.peak_level = 16'(peak_now);
        r.limit_flag = limit_now[0];
        return r;
    endfunction

    // Register write; only called while the block is idle.
    task automatic write_reg(cfg_index_t idx, int unsigned value);
        @(negedge aclk);
        cfg_wen = 1'b1;
        cfg_index = idx;
        cfg_wdata = value[16:0];
        case (idx)
            CFG_SAMPLE_FORMAT: r_format = value & 7;
            CFG_VALID_BITS:    r_valid = value & 63;
            CFG_PADDING_BITS:  r_pad = value & 31;
            CFG_CHANNEL_COUNT: r_chans = value & 15;
            CFG_MUTED:         r_mute = value & 1;
            CFG_TARGET_GAIN:   r_target = value & 17'h1FFFF;
            CFG_SMOOTHING:     r_smooth = value & 16'hFFFF;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wen = 1'b0;
    endtask

    task automatic drain();
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    // One request on the input channel, with optional idle cycles ahead of it.
    task automatic send_sample(logic [31:0] bits, logic sob);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = bits;
        s_tuser = sob;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(process_sample(bits, sob));
        @(negedge aclk);
    endtask

    task automatic end_burst();
        s_tvalid = 1'b0;
        drain();
    endtask

    // Sample biased toward the knee region, full scale and small values.
    function automatic logic [31:0] pick_sample();
        logic [31:0] b;
        int unsigned e;
        b = $urandom;
        case ($urandom_range(3))
            0: ;
            1: b = {b[31], 31'h7FFF_FFFF & (b >> $urandom_range(31))};
            default: begin
                if (r_format == FMT_FLOAT32) begin
                    e = $urandom_range(100, 135);
                    if ($urandom_range(30) == 0) e = $urandom_range(1) ? 255 : 0;
                    b[30:23] = 8'(e);
                end else if (r_format == FMT_PCM16) begin
                    b[15:14] = {b[15], ~b[15]};
                end else if (r_format == FMT_PCM24) begin
                    b[23:22] = {b[23], ~b[23]};
                end else begin
                    b[31:30] = {b[31], ~b[31]};
                end
            end
        endcase
        return b;
    endfunction

    task automatic test_pcm16_defaults();
        send_sample(32'h0000_0000, 1'b1);
        send_sample(32'h0000_7FFF, 1'b0);
        send_sample(32'h0000_8000, 1'b0);
        send_sample(32'hFFFF_6000, 1'b0);
        send_sample(32'h1234_0001, 1'b1);
        end_burst();
    endtask

    task automatic test_float_specials();
        write_reg(CFG_SAMPLE_FORMAT, FMT_FLOAT32);
        write_reg(CFG_SMOOTHING, 65535);
        write_reg(CFG_TARGET_GAIN, 130785);
        send_sample(32'h3F00_0000, 1'b1);  // 0.5
        send_sample(32'h7F80_0000, 1'b0);  // +inf
        send_sample(32'hFFC0_0001, 1'b0);  // nan
        send_sample(32'h0000_0001, 1'b1);  // denormal
        send_sample(32'hC3FF_FFFF, 1'b0);  // far past clipping
        send_sample(32'hBF7F_FFFF, 1'b0);
        end_burst();
    endtask

    task automatic test_pcm_widths();
        write_reg(CFG_SAMPLE_FORMAT, FMT_PCM32);
        write_reg(CFG_VALID_BITS, 32);
        write_reg(CFG_TARGET_GAIN, 4117);
        write_reg(CFG_SMOOTHING, 0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        end_burst();
        write_reg(CFG_SAMPLE_FORMAT, FMT_PCM24);
        write_reg(CFG_VALID_BITS, 2);
        write_reg(CFG_PADDING_BITS, 22);
        send_sample(32'h0040_0000, 1'b0);
        send_sample(32'h00C0_0000, 1'b0);
        end_burst();
        write_reg(CFG_VALID_BITS, 0);       // clamps up to two bits
        write_reg(CFG_PADDING_BITS, 31);
        send_sample(32'h0080_0000, 1'b0);
        end_burst();
        write_reg(CFG_VALID_BITS, 63);      // clamps down to 32 bits
        write_reg(CFG_PADDING_BITS, 0);
        send_sample(32'h007F_FFFF, 1'b0);
        end_burst();
    endtask

    task automatic test_pass_and_mute();
        write_reg(CFG_SAMPLE_FORMAT, 4);
        write_reg(CFG_MUTED, 1);
        send_sample(32'hDEAD_BEEF, 1'b0);
        end_burst();
        write_reg(CFG_SAMPLE_FORMAT, 7);
        send_sample(32'h0123_4567, 1'b1);
        end_burst();
        write_reg(CFG_SAMPLE_FORMAT, FMT_PCM16);
        send_sample(32'h0000_7FFF, 1'b0);
        end_burst();
        write_reg(CFG_MUTED, 0);
    endtask

    task automatic test_channel_counts();
        write_reg(CFG_CHANNEL_COUNT, 0);
        write_reg(CFG_TARGET_GAIN, 65536);
        write_reg(CFG_SMOOTHING, 30000);
        send_sample(32'h0000_4000, 1'b0);
        send_sample(32'h0000_4000, 1'b0);
        end_burst();
        write_reg(CFG_CHANNEL_COUNT, 15);
        repeat (3) send_sample(32'h0000_C000, 1'b0);
        end_burst();
    endtask

    // Random phase: fresh settings before each run of blocks of frames.
    task automatic test_random_phase(int idle_pct, int stall_pct, int n_items);
        send_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        for (int done = 0; done < n_items; ) begin
            write_reg(CFG_SAMPLE_FORMAT, $urandom_range(9) == 0 ? $urandom_range(4, 7)
                                                                : $urandom_range(3));
            write_reg(CFG_VALID_BITS, $urandom_range(7) == 0 ? $urandom_range(63)
                                                             : $urandom_range(2, 32));
            write_reg(CFG_PADDING_BITS, $urandom_range(3) == 0 ? $urandom_range(31)
                                                               : $urandom_range(8));
            write_reg(CFG_CHANNEL_COUNT, $urandom_range(9) == 0 ? $urandom_range(15)
                                                                : $urandom_range(1, 8));
            write_reg(CFG_MUTED, $urandom_range(9) == 0);
            write_reg(CFG_TARGET_GAIN, $urandom_range(1) ? $urandom_range(4117, 130785)
                                                         : $urandom_range(131071));
            write_reg(CFG_SMOOTHING, $urandom_range(2) == 0 ? 65535 : $urandom_range(65535));
            for (int k = 0; k < 30; k++) begin
                send_sample(pick_sample(), $urandom_range(15) == 0);
                done++;
            end
            end_burst();
        end
    endtask

    // Sink: random back-pressure at the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Result checker.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result sample_out=%h", m_tdata[31:0]);
                failed = 1'b1;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.sample_out) begin
                    $error("sample_out expected %h actual %h", want.sample_out, m_tdata[31:0]);
                    failed = 1'b1;
                end
                if (m_tdata[47:32] !== want.peak_level) begin
                    $error("peak_level expected %h actual %h", want.peak_level, m_tdata[47:32]);
                    failed = 1'b1;
                end
                if (m_tuser !== want.limit_flag) begin
                    $error("limit_flag expected %b actual %b", want.limit_flag, m_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on cycles with no request moving on either side and no register write.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        build_decay_rom();
        r_format = FMT_PCM16; r_valid = 16; r_pad = 0; r_chans = 2;
        r_mute = 0; r_target = 65536; r_smooth = 137;
        gain_now = 65536; chan_pos = 0; peak_now = 0; limit_now = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_pcm16_defaults();
        test_float_specials();
        test_pcm_widths();
        test_pass_and_mute();
        test_channel_counts();
        test_random_phase(0, 0, 150);
        test_random_phase(76, 0, 150);
        test_random_phase(0, 76, 150);
        test_random_phase(7, 7, 150);

        drain();
        if (!failed) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
